@@ src/rsa_mme_pkg.sv @@
// Shared types and constants of the RSA modular exponentiation unit.
package rsa_mme_pkg;

  localparam int WORD_BITS = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

  // Operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [WORD_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] result;
    logic                 error;
  } out_t;

  // Status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

@@ src/rsa_modular_exponentiation_unit.sv @@
// Top level of the RSA modular exponentiation unit: sequencer, registers, result stage.
//
// Usage: write modulus (index 0), public exponent (1) and private exponent (2)
// on the cfg_ channel while the block is idle; cfg_ready is always high.
// Each input transfer (in_valid high, in_stall low) carries op and value; op
// selects encrypt (public exponent) or decrypt (private exponent). One result
// transfer follows per input: result = value^exp mod modulus, error set with
// result 0 when the modulus is zero.
// Method: right-to-left square-and-multiply on one shared bit-serial modular
// multiplier, one multiplier bit per cycle. After the accept cycle the input is
// reduced; each exponent bit below the top set bit costs a check, a square and,
// if set, a multiply; the top set bit costs a check and a multiply; a finish
// state then loads the result. A zero modulus skips the reduction and the
// exponent loop.
// The block takes one item at a time; in_stall stays high while it works.
// The result register parts the output side: the next item is accepted while
// a finished result still waits, and a stalled result holds its value.
// Reset: modulus and exponent registers read 0, no result pending, block idle.
module rsa_modular_exponentiation_unit
  import rsa_mme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] modulus_r, modulus_nxt;
  logic [WORD_BITS-1:0] pub_exp_r, pub_exp_nxt;
  logic [WORD_BITS-1:0] priv_exp_r, priv_exp_nxt;
  logic [WORD_BITS-1:0] exp_r, exp_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] base_r, base_nxt;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_a;
  logic [WORD_BITS-1:0] mm_b;
  logic [WORD_BITS-1:0] mm_p;
  mm_status_t           mm_st;

  // Shared multiplier: reduces the input, then does every square and multiply
  rsa_mme_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .n      (modulus_r),
    .p      (mm_p),
    .status (mm_st)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    modulus_nxt   = modulus_r;
    pub_exp_nxt   = pub_exp_r;
    priv_exp_nxt  = priv_exp_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    err_nxt       = err_r;
    out_data_nxt  = out_data_r;
    // drop the pending result once it transfers
    out_valid_nxt = out_valid_r && out_stall;
    mm_start      = 1'b0;
    mm_a          = acc_r;
    mm_b          = base_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODULUS:     modulus_nxt  = cfg_data;
        CFG_PUBLIC_EXP:  pub_exp_nxt  = cfg_data;
        CFG_PRIVATE_EXP: priv_exp_nxt = cfg_data;
        default:         ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          exp_nxt = (in_data.op == OP_DECRYPT) ? priv_exp_r : pub_exp_r;
          if (modulus_r == '0) begin
            acc_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            // reduce the input as 1 * value mod n; seed the product with 1 mod n
            mm_start  = 1'b1;
            mm_a      = WORD_BITS'(1);
            mm_b      = in_data.value;
            acc_nxt   = (modulus_r == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            err_nxt   = 1'b0;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_st.done) begin
          base_nxt  = mm_p;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (exp_r == '0) begin
          state_nxt = ST_FINISH;
        end else if (exp_r[0]) begin
          mm_start  = 1'b1;
          mm_a      = acc_r;
          mm_b      = base_r;
          state_nxt = ST_MUL;
        end else begin
          mm_start  = 1'b1;
          mm_a      = base_r;
          mm_b      = base_r;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_st.done) begin
          acc_nxt = mm_p;
          // skip the square after the top set bit
          if (exp_r[WORD_BITS-1:1] == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            mm_start  = 1'b1;
            mm_a      = base_r;
            mm_b      = base_r;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_st.done) begin
          base_nxt  = mm_p;
          exp_nxt   = exp_r >> 1;
          state_nxt = ST_CHECK;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.result = acc_r;
          out_data_nxt.error  = err_r;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= '0;
      pub_exp_r   <= '0;
      priv_exp_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      pub_exp_r   <= pub_exp_nxt;
      priv_exp_r  <= priv_exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_st.busy)
    else $error("multiplier started while busy");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mm_st.done |-> (state_r == ST_REDUCE || state_r == ST_MUL || state_r == ST_SQR))
    else $error("multiplier done outside a wait state");

  a_product_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (mm_st.done && modulus_r != '0) |-> (mm_p < modulus_r))
    else $error("product not reduced below modulus");

  a_error_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error) |-> (out_data_r.result == '0))
    else $error("error result carries nonzero value");
`endif

endmodule

@@ src/rsa_mme_modmul.sv @@
// Bit-serial interleaved modular multiplier: p = a * b mod n, one bit of b per cycle.
module rsa_mme_modmul
  import rsa_mme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] n,
  output logic [WORD_BITS-1:0] p,
  output mm_status_t           status
);

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam int EXT_W = WORD_BITS + 2;

  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [EXT_W-1:0] sum;
  logic [EXT_W-1:0] n1;
  logic [EXT_W-1:0] n2;
  logic [WORD_BITS-1:0] step;

  // 2*acc + bit*a stays below 3n when acc and a are below n
  always_comb begin
    n1  = EXT_W'(n);
    n2  = {1'b0, n, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (b_r[WORD_BITS-1] ? EXT_W'(a_r) : '0);
    priority if (sum >= n2) begin
      step = WORD_BITS'(sum - n2);
    end else if (sum >= n1) begin
      step = WORD_BITS'(sum - n1);
    end else begin
      step = WORD_BITS'(sum);
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(WORD_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = step;
      b_nxt   = {b_r[WORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign p           = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule
